### rtl/two_bar_first_fit_packer_core_macros.svh
// ----------------------------------------------------------------------------
// two-bar first-fit packer assertion macros
// shared property shorthands for same-cycle and next-cycle implications
// ----------------------------------------------------------------------------
`ifndef TWO_BAR_FIRST_FIT_PACKER_CORE_MACROS_SVH
`define TWO_BAR_FIRST_FIT_PACKER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TBFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbfp assertion failed");

// antecedent implies consequent in the next cycle
`define TBFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbfp assertion failed");

`endif

### rtl/tbfp_pkg.sv
// ----------------------------------------------------------------------------
// tbfp_pkg
// widths, defaults, command codes and shared types of the two-bar packer
// ----------------------------------------------------------------------------
package tbfp_pkg;

  localparam int HEIGHT_W       = 16;
  localparam int COPIES_W       = 7;
  localparam int BIN_INDEX_W    = 10;
  localparam int BINS_USED_W    = 11;
  localparam int DEF_NUM_BINS   = 1024;
  localparam int DEF_MAX_COPIES = 64;

  localparam logic [HEIGHT_W-1:0] CAP_RESET = 16'hFFFF;

  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // result of the shared fit check on one bin
  typedef struct packed {
    logic                fits_first;
    logic                fits_second;
    logic [HEIGHT_W-1:0] sum_first;
    logic [HEIGHT_W-1:0] sum_second;
  } fit_res_t;

  // control group towards the fill store
  typedef struct packed {
    logic                clr;
    logic                wr_en;
    logic [HEIGHT_W-1:0] wr_data;
  } mem_cmd_t;

endpackage

### rtl/tbfp_fit_unit.sv
// ----------------------------------------------------------------------------
// tbfp_fit_unit
// shared add and compare unit: checks one bin fill against both bar heights
// ----------------------------------------------------------------------------
module tbfp_fit_unit (
  input  logic [tbfp_pkg::HEIGHT_W-1:0] fill_i,
  input  logic [tbfp_pkg::HEIGHT_W-1:0] first_height_i,
  input  logic [tbfp_pkg::HEIGHT_W-1:0] second_height_i,
  input  logic [tbfp_pkg::HEIGHT_W-1:0] capacity_i,
  output tbfp_pkg::fit_res_t            fit_o
);
  import tbfp_pkg::*;

  logic [HEIGHT_W:0] sum_first;
  logic [HEIGHT_W:0] sum_second;

  assign sum_first  = {1'b0, fill_i} + {1'b0, first_height_i};
  assign sum_second = {1'b0, fill_i} + {1'b0, second_height_i};

  assign fit_o.fits_first  = sum_first  <= {1'b0, capacity_i};
  assign fit_o.fits_second = sum_second <= {1'b0, capacity_i};
  assign fit_o.sum_first   = sum_first[HEIGHT_W-1:0];
  assign fit_o.sum_second  = sum_second[HEIGHT_W-1:0];

endmodule

### rtl/tbfp_fill_mem.sv
// ----------------------------------------------------------------------------
// tbfp_fill_mem
// bin fill store with registered read and a high-water mark; bins at or
// above the mark read as empty, so a clear only resets the mark
// ----------------------------------------------------------------------------
module tbfp_fill_mem #(
  parameter int NUM_BINS = tbfp_pkg::DEF_NUM_BINS,
  parameter int IDX_W    = $clog2(NUM_BINS),
  parameter int CNT_W    = $clog2(NUM_BINS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tbfp_pkg::mem_cmd_t            cmd_i,
  input  logic [IDX_W-1:0]              wr_addr_i,
  input  logic [IDX_W-1:0]              rd_addr_i,
  output logic [tbfp_pkg::HEIGHT_W-1:0] rd_data_o,
  output logic [CNT_W-1:0]              high_mark_o
);
  import tbfp_pkg::*;

  logic [HEIGHT_W-1:0] mem_q [NUM_BINS];
  logic [HEIGHT_W-1:0] rd_data_q;
  logic                rd_zero_q;
  logic [CNT_W-1:0]    high_mark_q;
  logic [CNT_W-1:0]    wr_end;

  assign wr_end = CNT_W'(wr_addr_i) + CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr_i] <= cmd_i.wr_data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_mark_q <= '0;
      rd_zero_q   <= 1'b1;
    end else begin
      rd_zero_q <= CNT_W'(rd_addr_i) >= high_mark_q;
      if (cmd_i.clr) begin
        high_mark_q <= '0;
      end else if (cmd_i.wr_en && (wr_end > high_mark_q)) begin
        high_mark_q <= wr_end;
      end
    end
  end

  assign rd_data_o   = rd_zero_q ? '0 : rd_data_q;
  assign high_mark_o = high_mark_q;

endmodule

### rtl/two_bar_first_fit_packer_core.sv
// per copy: ST_SCAN_START, then ST_SCAN tests adjacent bin pairs in turn (at most NUM_BINS - 1)
// a placed copy adds ST_WR_A, ST_WR_B, ST_COUNT_REQ and an ST_COUNT_CHK per bin the count reads:
//   each bin it advances past, plus one when it stops on an empty bin below the mark
// an overflowed copy ends with its last test; an item runs its copies in turn (up to 64)
// results are one-cycle strobes in the cycle after their copy, the receiver cannot stall, last one
// coincides with busy dropping; a clear finishes as it is accepted; reset empties the store
// ----------------------------------------------------------------------------
// two_bar_first_fit_packer_core
// first-fit placement of two-bar charts into adjacent bins, one result per copy
// ----------------------------------------------------------------------------
module two_bar_first_fit_packer_core #(
  parameter int NUM_BINS   = tbfp_pkg::DEF_NUM_BINS,
  parameter int MAX_COPIES = tbfp_pkg::DEF_MAX_COPIES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cmd_i,
  input  logic [tbfp_pkg::HEIGHT_W-1:0]    first_height_i,
  input  logic [tbfp_pkg::HEIGHT_W-1:0]    second_height_i,
  input  logic [tbfp_pkg::COPIES_W-1:0]    copies_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tbfp_pkg::HEIGHT_W-1:0]    cfg_data_i,
  output logic                             result_valid_o,
  output logic [tbfp_pkg::BIN_INDEX_W-1:0] bin_index_o,
  output logic [tbfp_pkg::BINS_USED_W-1:0] bins_used_o,
  output logic                             overflow_o,
  output logic                             last_o
);
  import tbfp_pkg::*;
  `include "two_bar_first_fit_packer_core_macros.svh"

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int CNT_W = $clog2(NUM_BINS + 1);
  localparam int CPY_W = $clog2(MAX_COPIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_START,
    ST_SCAN,
    ST_WR_A,
    ST_WR_B,
    ST_COUNT_REQ,
    ST_COUNT_CHK
  } state_e;

  state_e               state_q, state_d;
  logic [HEIGHT_W-1:0]  cap_q;
  logic [HEIGHT_W-1:0]  h1_q, h1_d;
  logic [HEIGHT_W-1:0]  h2_q, h2_d;
  logic [CPY_W-1:0]     rem_q, rem_d;
  logic [IDX_W-1:0]     scan_q, scan_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic                 prev_ff_q, prev_ff_d;
  logic [HEIGHT_W-1:0]  prev_sum_q, prev_sum_d;
  logic [IDX_W-1:0]     wr_idx_q, wr_idx_d;
  logic [HEIGHT_W-1:0]  wr_b_q, wr_b_d;
  logic                 res_valid_q, res_valid_d;
  logic [BIN_INDEX_W-1:0] bin_index_q, bin_index_d;
  logic [BINS_USED_W-1:0] bins_used_q, bins_used_d;
  logic                 overflow_q, overflow_d;
  logic                 last_q, last_d;

  mem_cmd_t             mem_cmd;
  logic [IDX_W-1:0]     mem_wr_addr;
  logic [IDX_W-1:0]     mem_rd_addr;
  logic [HEIGHT_W-1:0]  rd_data;
  logic [CNT_W-1:0]     high_mark;
  fit_res_t             fit;

  logic                 copy_done;
  logic                 done_ovf;
  logic [CNT_W-1:0]     used_inc;
  logic [CPY_W-1:0]     copies_sat;
  logic                 clr_accept;

  tbfp_fill_mem #(
    .NUM_BINS (NUM_BINS),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_fill_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (mem_cmd),
    .wr_addr_i   (mem_wr_addr),
    .rd_addr_i   (mem_rd_addr),
    .rd_data_o   (rd_data),
    .high_mark_o (high_mark)
  );

  tbfp_fit_unit u_fit_unit (
    .fill_i          (rd_data),
    .first_height_i  (h1_q),
    .second_height_i (h2_q),
    .capacity_i      (cap_q),
    .fit_o           (fit)
  );

  assign busy        = (state_q != ST_IDLE);
  // capacity only changes between items
  assign cfg_ready_o = !busy;
  assign used_inc    = used_q + CNT_W'(1);
  assign copies_sat  = (copies_i > COPIES_W'(MAX_COPIES)) ? CPY_W'(MAX_COPIES)
                                                          : CPY_W'(copies_i);
  assign clr_accept  = start && !busy && (cmd_i == CMD_CLEAR);

  always_comb begin
    state_d     = state_q;
    h1_d        = h1_q;
    h2_d        = h2_q;
    rem_d       = rem_q;
    scan_d      = scan_q;
    used_d      = used_q;
    prev_ff_d   = prev_ff_q;
    prev_sum_d  = prev_sum_q;
    wr_idx_d    = wr_idx_q;
    wr_b_d      = wr_b_q;
    res_valid_d = 1'b0;
    bin_index_d = bin_index_q;
    bins_used_d = bins_used_q;
    overflow_d  = overflow_q;
    last_d      = last_q;
    mem_cmd     = '0;
    mem_wr_addr = '0;
    mem_rd_addr = '0;
    copy_done   = 1'b0;
    done_ovf    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (cmd_i == CMD_CLEAR) begin
            mem_cmd.clr = 1'b1;
            used_d      = '0;
          end else if (copies_sat != '0) begin
            h1_d    = first_height_i;
            h2_d    = second_height_i;
            rem_d   = copies_sat;
            state_d = ST_SCAN_START;
          end
        end
      end
      ST_SCAN_START: begin
        mem_rd_addr = '0;
        scan_d      = '0;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        // rd_data holds bin scan_q, prev regs hold bin scan_q-1
        if ((scan_q != '0) && prev_ff_q && fit.fits_second) begin
          wr_idx_d = scan_q - IDX_W'(1);
          wr_b_d   = fit.sum_second;
          state_d  = ST_WR_A;
        end else if ((scan_q == IDX_W'(NUM_BINS - 1)) || (CNT_W'(scan_q) > high_mark)) begin
          // past the mark every pair is empty and tested alike: no fit anywhere
          copy_done = 1'b1;
          done_ovf  = 1'b1;
        end else begin
          prev_ff_d   = fit.fits_first;
          prev_sum_d  = fit.sum_first;
          scan_d      = scan_q + IDX_W'(1);
          mem_rd_addr = scan_q + IDX_W'(1);
        end
      end
      ST_WR_A: begin
        mem_cmd.wr_en   = 1'b1;
        mem_cmd.wr_data = prev_sum_q;
        mem_wr_addr     = wr_idx_q;
        state_d         = ST_WR_B;
      end
      ST_WR_B: begin
        mem_cmd.wr_en   = 1'b1;
        mem_cmd.wr_data = wr_b_q;
        mem_wr_addr     = wr_idx_q + IDX_W'(1);
        state_d         = ST_COUNT_REQ;
      end
      ST_COUNT_REQ: begin
        // fills only grow, so the leading-used count resumes where it stopped
        if (used_q >= high_mark) begin
          copy_done = 1'b1;
        end else begin
          mem_rd_addr = used_q[IDX_W-1:0];
          state_d     = ST_COUNT_CHK;
        end
      end
      ST_COUNT_CHK: begin
        if (rd_data != '0) begin
          used_d = used_inc;
          if (used_inc < high_mark) begin
            mem_rd_addr = used_inc[IDX_W-1:0];
          end else begin
            copy_done = 1'b1;
          end
        end else begin
          copy_done = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (copy_done) begin
      res_valid_d = 1'b1;
      overflow_d  = done_ovf;
      bin_index_d = done_ovf ? '0 : BIN_INDEX_W'(wr_idx_q);
      bins_used_d = BINS_USED_W'(used_d);
      last_d      = (rem_q == CPY_W'(1));
      rem_d       = rem_q - CPY_W'(1);
      state_d     = (rem_q == CPY_W'(1)) ? ST_IDLE : ST_SCAN_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      rem_q       <= '0;
      used_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      used_q      <= used_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q        <= h1_d;
    h2_q        <= h2_d;
    scan_q      <= scan_d;
    prev_ff_q   <= prev_ff_d;
    prev_sum_q  <= prev_sum_d;
    wr_idx_q    <= wr_idx_d;
    wr_b_q      <= wr_b_d;
    bin_index_q <= bin_index_d;
    bins_used_q <= bins_used_d;
    overflow_q  <= overflow_d;
    last_q      <= last_d;
  end

  assign result_valid_o = res_valid_q;
  assign bin_index_o    = bin_index_q;
  assign bins_used_o    = bins_used_q;
  assign overflow_o     = overflow_q;
  assign last_o         = last_q;

  // a result that leaves the block idle must close its item
  `TBFP_ASSERT_IMP(a_idle_result_is_last, clk_i, rst_ni, result_valid_o && !busy, last_o)
  // the leading-used count never runs past the written region
  `TBFP_ASSERT_IMP(a_used_within_mark, clk_i, rst_ni, 1'b1, used_q <= high_mark)
  // a clear transaction empties the store and the count together
  `TBFP_ASSERT_NXT(a_clear_empties, clk_i, rst_ni, clr_accept, (high_mark == '0) && (used_q == '0))
  // an overflowed copy reports bin zero
  `TBFP_ASSERT_IMP(a_overflow_index, clk_i, rst_ni, result_valid_o && overflow_o, bin_index_o == '0)

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives place and clear commands and capacity writes into the two-bar packer,
// predicts every copy placement, and checks each result strobe in order
// ----------------------------------------------------------------------------
module tb;
  import tbfp_pkg::*;

  localparam int NUM_BINS   = DEF_NUM_BINS;
  localparam int MAX_COPIES = DEF_MAX_COPIES;
  localparam int SETTLE     = 20;   // idle cycles before a capacity write or a hold ends
  localparam int TAIL       = 25;   // last commands go out back to back
  localparam int ITEM_GOAL  = 170;

  typedef enum logic [1:0] {JOB_CHART, JOB_CAP, JOB_HOLD} job_kind_e;

  typedef struct {
    job_kind_e             kind;
    logic                  cmd;
    logic [HEIGHT_W-1:0]   h1;
    logic [HEIGHT_W-1:0]   h2;
    logic [COPIES_W-1:0]   copies;
    logic [HEIGHT_W-1:0]   cap;
  } chart_job_t;

  typedef struct packed {
    logic [BIN_INDEX_W-1:0] bin_index;
    logic [BINS_USED_W-1:0] bins_used;
    logic                   overflow;
    logic                   last;
  } copy_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   cmd_i = CMD_PLACE;
  logic [HEIGHT_W-1:0]    first_height_i = '0;
  logic [HEIGHT_W-1:0]    second_height_i = '0;
  logic [COPIES_W-1:0]    copies_i = '0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [HEIGHT_W-1:0]    cfg_data_i = '0;
  logic                   result_valid_o;
  logic [BIN_INDEX_W-1:0] bin_index_o;
  logic [BINS_USED_W-1:0] bins_used_o;
  logic                   overflow_o;
  logic                   last_o;

  chart_job_t   pending_jobs[$];
  copy_result_t expected_copies[$];
  chart_job_t   held_job;

  logic [HEIGHT_W-1:0] fill_model [NUM_BINS];
  logic [HEIGHT_W-1:0] cap_model;

  int errors = 0;
  int items_sent = 0;
  int cap_writes = 0;
  int copies_checked = 0;
  int overflows_seen = 0;
  int pause_cycles = 0;
  int quiet_cycles = 0;

  two_bar_first_fit_packer_core #(
    .NUM_BINS  (NUM_BINS),
    .MAX_COPIES(MAX_COPIES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .first_height_i (first_height_i),
    .second_height_i(second_height_i),
    .copies_i       (copies_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .bin_index_o    (bin_index_o),
    .bins_used_o    (bins_used_o),
    .overflow_o     (overflow_o),
    .last_o         (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int leading_used_bins();
    int n;
    n = 0;
    while (n < NUM_BINS && fill_model[n] != '0) n++;
    return n;
  endfunction

  // first-fit over adjacent bin pairs, one expected result per copy; a clear empties the model bins
  function automatic void place_chart(chart_job_t j);
    int           n;
    int           slot;
    bit           hit;
    copy_result_t r;
    if (j.cmd == CMD_CLEAR) begin
      for (int b = 0; b < NUM_BINS; b++) fill_model[b] = '0;
      return;
    end
    n = (int'(j.copies) > MAX_COPIES) ? MAX_COPIES : int'(j.copies);
    for (int k = 0; k < n; k++) begin
      slot = 0;
      hit  = 1'b0;
      while (!hit && slot + 1 < NUM_BINS) begin
        if (int'(fill_model[slot]) + int'(j.h1) <= int'(cap_model) &&
            int'(fill_model[slot+1]) + int'(j.h2) <= int'(cap_model))
          hit = 1'b1;
        else
          slot++;
      end
      if (hit) begin
        fill_model[slot]   = fill_model[slot] + j.h1;
        fill_model[slot+1] = fill_model[slot+1] + j.h2;
        r.bin_index = BIN_INDEX_W'(slot);
        r.overflow  = 1'b0;
      end else begin
        r.bin_index = '0;
        r.overflow  = 1'b1;
      end
      r.bins_used = BINS_USED_W'(leading_used_bins());
      r.last      = (k + 1 == n);
      expected_copies = {expected_copies, r};
    end
  endfunction

  task automatic log_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
    errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // driver: one command or capacity write in flight at a time
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_start;
    logic nxt_cfg;
    if (!rst_ni) begin
      start        <= 1'b0;
      cfg_valid_i  <= 1'b0;
      pause_cycles = 0;
      quiet_cycles = 0;
      cap_model    = CAP_RESET;
      for (int b = 0; b < NUM_BINS; b++) fill_model[b] = '0;
    end else begin
      nxt_start = start;
      nxt_cfg   = cfg_valid_i;
      if (start && !busy) begin
        place_chart(held_job);
        items_sent++;
        nxt_start = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cap_model = held_job.cap;
        cap_writes++;
        nxt_cfg = 1'b0;
      end
      if (expected_copies.size() != 0 || busy || start || cfg_valid_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (!nxt_start && !nxt_cfg) begin
        if (pause_cycles > 0) begin
          pause_cycles--;
        end else if (pending_jobs.size() != 0) begin
          if (pending_jobs[0].kind == JOB_CHART) begin
            held_job = pending_jobs.pop_front();
            cmd_i           <= held_job.cmd;
            first_height_i  <= held_job.h1;
            second_height_i <= held_job.h2;
            copies_i        <= held_job.copies;
            nxt_start = 1'b1;
            if (pending_jobs.size() > TAIL && $urandom_range(0, 9) < 4)
              pause_cycles = $urandom_range(1, 9);
          end else if (quiet_cycles >= SETTLE) begin
            // register writes and holds wait for the block to go quiet
            held_job = pending_jobs.pop_front();
            if (held_job.kind == JOB_CAP) begin
              cfg_data_i <= held_job.cap;
              nxt_cfg = 1'b1;
            end
            quiet_cycles = 0;
          end
        end
      end
      start       <= nxt_start;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // monitor: every strobe is checked against the oldest expected copy
  always @(posedge clk_i) begin
    copy_result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_copies.size() == 0) begin
        log_mismatch("result with nothing pending, bin_index", 16'(bin_index_o), 16'd0);
      end else begin
        want = expected_copies.pop_front();
        copies_checked++;
        if (overflow_o === 1'b1) overflows_seen++;
        if (bin_index_o !== want.bin_index)
          log_mismatch("bin_index", 16'(bin_index_o), 16'(want.bin_index));
        if (bins_used_o !== want.bins_used)
          log_mismatch("bins_used", 16'(bins_used_o), 16'(want.bins_used));
        if (overflow_o !== want.overflow)
          log_mismatch("overflow", 16'(overflow_o), 16'(want.overflow));
        if (last_o !== want.last)
          log_mismatch("last", 16'(last_o), 16'(want.last));
      end
    end
  end

  task automatic queue_chart(input logic c, input logic [HEIGHT_W-1:0] a,
                             input logic [HEIGHT_W-1:0] b, input logic [COPIES_W-1:0] n);
    pending_jobs = {pending_jobs, chart_job_t'{JOB_CHART, c, a, b, n, 16'd0}};
  endtask

  task automatic queue_cap(input logic [HEIGHT_W-1:0] c);
    pending_jobs = {pending_jobs, chart_job_t'{JOB_CAP, CMD_PLACE, 16'd0, 16'd0, 7'd0, c}};
  endtask

  function automatic logic [HEIGHT_W-1:0] pick_height(input int c);
    int r;
    r = $urandom_range(0, 99);
    if (c < 65535 && r < 10) return HEIGHT_W'($urandom_range(c + 1, 65535));
    if (r < 20) return HEIGHT_W'(c);
    if (r < 28) return '0;
    return HEIGHT_W'($urandom_range(0, c));
  endfunction

  initial begin
    int queued;
    int round;
    int cap;
    int sel;
    int run_len;
    int r;
    logic [COPIES_W-1:0] n;

    // directed: extremes, saturation, clear, over-height, zero capacity
    queue_cap(16'hFFFF);
    queue_chart(CMD_PLACE, 16'hFFFF, 16'h0000, 7'd1);
    queue_chart(CMD_PLACE, 16'h0000, 16'hFFFF, 7'd2);
    queue_chart(CMD_PLACE, 16'h0001, 16'h0001, 7'd0);
    queue_chart(CMD_PLACE, 16'h8000, 16'h7FFF, 7'd127);
    queue_chart(CMD_CLEAR, 16'h0000, 16'h0000, 7'd0);
    queue_chart(CMD_PLACE, 16'h5555, 16'hAAAA, 7'd3);
    queue_chart(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 7'h7F);
    queue_cap(16'd100);
    queue_chart(CMD_PLACE, 16'd101, 16'd0, 7'd2);
    queue_chart(CMD_PLACE, 16'd100, 16'd100, 7'd1);
    queue_cap(16'd0);
    queue_chart(CMD_CLEAR, 16'd0, 16'd0, 7'd0);
    queue_chart(CMD_PLACE, 16'd0, 16'd0, 7'd2);
    queue_chart(CMD_PLACE, 16'd1, 16'd0, 7'd1);
    // fill every bin, then hit a full store
    queue_cap(16'd1);
    queue_chart(CMD_CLEAR, 16'd0, 16'd0, 7'd0);
    repeat (8) queue_chart(CMD_PLACE, 16'd1, 16'd1, 7'd64);
    queue_chart(CMD_PLACE, 16'd0, 16'd0, 7'd2);
    queue_chart(CMD_PLACE, 16'd1, 16'd0, 7'd2);
    queue_chart(CMD_CLEAR, 16'd0, 16'd0, 7'd0);
    queued = 24;

    // random rounds, each at its own capacity and starting from empty bins
    round = 0;
    while (queued < ITEM_GOAL) begin
      sel = $urandom_range(0, 4);
      case (sel)
        0: cap = 1;
        1: cap = 65535;
        2: cap = $urandom_range(2, 64);
        default: cap = $urandom_range(65, 65534);
      endcase
      queue_cap(HEIGHT_W'(cap));
      queue_chart(CMD_CLEAR, HEIGHT_W'($urandom), HEIGHT_W'($urandom), COPIES_W'($urandom));
      queued++;
      run_len = $urandom_range(8, 16);
      for (int i = 0; i < run_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 7) begin
          queue_chart(CMD_CLEAR, HEIGHT_W'($urandom), HEIGHT_W'($urandom),
                      COPIES_W'($urandom));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 5)       n = '0;
          else if (r < 10) n = COPIES_W'($urandom_range(64, 127));
          else if (r < 25) n = COPIES_W'($urandom_range(7, 20));
          else             n = COPIES_W'($urandom_range(1, 6));
          queue_chart(CMD_PLACE, pick_height(cap), pick_height(cap), n);
        end
        queued++;
        if (round % 3 == 1 && i == run_len / 2)
          pending_jobs = {pending_jobs,
                          chart_job_t'{JOB_HOLD, CMD_PLACE, 16'd0, 16'd0, 7'd0, 16'd0}};
      end
      round++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_jobs.size() != 0 || start || cfg_valid_i) @(posedge clk_i);
    while (expected_copies.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("sent %0d commands over %0d capacity settings (%0d register writes)",
             items_sent, round + 4, cap_writes);
    $display("checked %0d copy results, %0d of them overflows", copies_checked, overflows_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("timeout with %0d results still expected", expected_copies.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### two_bar_first_fit_packer_core.f
+incdir+rtl
rtl/tbfp_pkg.sv
rtl/tbfp_fit_unit.sv
rtl/tbfp_fill_mem.sv
rtl/two_bar_first_fit_packer_core.sv
bench/tb.sv
